### rtl/sek_pkg.sv
// ----------------------------------------------------------------------------
// sek_pkg
// shared types and constants of the squared-exponential kernel unit
// ----------------------------------------------------------------------------
package sek_pkg;

    localparam int CFG_W      = 24;
    localparam int Z_W        = 16;
    localparam int IDX_W      = 20;
    localparam int DIST_W     = 40;
    localparam int COV_W      = 32;
    localparam int IN_DATA_W  = 72;
    localparam int NF_W       = 7;

    localparam logic [31:0] LN2_Q32      = 32'd2977044472;
    localparam logic [32:0] ONE_Q32      = 33'h1_0000_0000;
    localparam logic [3:0]  SERIES_TERMS = 4'd10;
    localparam logic [4:0]  RANGE_STEPS  = 5'd5;

    typedef enum logic [2:0] {
        REG_HALF_INV_SQ    = 3'd0,
        REG_VERTICAL_SCALE = 3'd1,
        REG_DIAG_NOISE     = 3'd2,
        REG_ADD_NOISE      = 3'd3,
        REG_NUM_FEATURES   = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACC,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_RANGE,
        OP_DIVN,
        OP_HMUL,
        OP_HDIV,
        OP_HUPD,
        OP_SHIFT,
        OP_SCALE,
        OP_LOAD
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] step;
        logic [3:0] term;
    } cmd_t;

    typedef struct packed {
        logic complete;
        logic cutoff;
        logic out_free;
    } status_t;

endpackage

### rtl/sek_datapath.sv
// ----------------------------------------------------------------------------
// sek_datapath
// configuration registers, distance accumulator and exponential datapath
// ----------------------------------------------------------------------------
module sek_datapath #(
    parameter int MAX_FEATURES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sek_pkg::cmd_t                 cmd,
    output sek_pkg::status_t              status,
    input  logic                          cfg_valid,
    input  logic [2:0]                    cfg_index,
    input  logic [sek_pkg::CFG_W-1:0]     cfg_data,
    input  logic [sek_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sek_pkg::COV_W-1:0]     m_tdata
);

    localparam int CNT_W = $clog2(MAX_FEATURES + 1);
    localparam logic [8:0] MAX_N = 9'(MAX_FEATURES);

    // reciprocal of the series divisor, ceil(2^(32+s)/k) with 2^s >= k
    function automatic logic [32:0] recip_magic(input logic [3:0] k);
        case (k)
            4'd3:    recip_magic = 33'd5726623062;
            4'd5:    recip_magic = 33'd6871947674;
            4'd6:    recip_magic = 33'd5726623062;
            4'd7:    recip_magic = 33'd4908534053;
            4'd9:    recip_magic = 33'd7635497416;
            4'd10:   recip_magic = 33'd6871947674;
            default: recip_magic = 33'h1_0000_0000;
        endcase
    endfunction

    function automatic logic [2:0] recip_shift(input logic [3:0] k);
        case (k)
            4'd2:    recip_shift = 3'd1;
            4'd3:    recip_shift = 3'd2;
            4'd4:    recip_shift = 3'd2;
            4'd5:    recip_shift = 3'd3;
            4'd6:    recip_shift = 3'd3;
            4'd7:    recip_shift = 3'd3;
            4'd8:    recip_shift = 3'd3;
            4'd9:    recip_shift = 3'd4;
            4'd10:   recip_shift = 3'd4;
            default: recip_shift = 3'd0;
        endcase
    endfunction

    logic [sek_pkg::CFG_W-1:0]  half_inv_sq_reg;
    logic [sek_pkg::CFG_W-1:0]  vertical_scale_reg;
    logic [sek_pkg::CFG_W-1:0]  diag_noise_reg;
    logic                       add_noise_reg;
    logic [sek_pkg::NF_W-1:0]   num_features_reg;

    logic [sek_pkg::DIST_W-1:0] acc_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [sek_pkg::DIST_W-1:0] dist_reg;
    logic                       diag_reg;
    logic [63:0]                p_reg;
    logic [36:0]                x_reg;
    logic [5:0]                 n_reg;
    logic [32:0]                t_reg;
    logic [31:0]                q_reg;
    logic [32:0]                e_reg;
    logic [sek_pkg::COV_W-1:0]  cov_reg;
    logic                       m_tvalid_reg;
    logic [sek_pkg::COV_W-1:0]  m_tdata_reg;

    logic signed [16:0] diff;
    logic [33:0]        sq;
    logic [40:0]        sum_wide;
    logic [39:0]        sum_sat;
    logic [8:0]         nf9;
    logic [8:0]         need9;
    logic [8:0]         cnt_inc9;
    logic               complete;
    logic [37:0]        ln2_shift;
    logic               ge_ln2;
    logic [63:0]        rt_prod;
    logic [32:0]        recip;
    logic [2:0]         recip_sh;
    logic [64:0]        div_prod;
    logic [31:0]        quot;
    logic [56:0]        scale_prod;
    logic [32:0]        cov_sum;
    logic [24:0]        kernel;

    // accumulate one feature pair
    assign diff     = 17'(signed'(s_tdata[15:0])) - 17'(signed'(s_tdata[31:16]));
    assign sq       = 34'(diff * diff);
    assign sum_wide = {1'b0, acc_reg} + 41'(sq);
    assign sum_sat  = sum_wide[40] ? {40{1'b1}} : sum_wide[39:0];

    assign nf9      = {2'b00, num_features_reg};
    assign need9    = (nf9 == 9'd0) ? 9'd1 : ((nf9 > MAX_N) ? MAX_N : nf9);
    assign cnt_inc9 = 9'(cnt_reg) + 9'd1;
    assign complete = (cnt_inc9 >= need9);

    // range reduction by ln 2
    assign ln2_shift = {6'd0, sek_pkg::LN2_Q32} << cmd.step[2:0];
    assign ge_ln2    = ({1'b0, x_reg} >= ln2_shift);

    // series step
    assign rt_prod  = 64'(x_reg[31:0]) * 64'(t_reg);
    assign recip    = recip_magic(cmd.term);
    assign recip_sh = recip_shift(cmd.term);
    assign div_prod = 65'(q_reg) * 65'(recip);
    assign quot     = 32'(div_prod[64:32] >> recip_sh);

    // output scaling
    assign scale_prod = 57'(vertical_scale_reg) * 57'(e_reg);
    assign kernel     = 25'((scale_prod + 57'h8000_0000) >> 32);
    assign cov_sum    = 33'(kernel) + (diag_reg ? 33'(diag_noise_reg) : 33'd0);

    assign status.complete = complete;
    assign status.cutoff   = (p_reg[63:45] != 19'd0);
    assign status.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_inv_sq_reg    <= 24'd65536;
            vertical_scale_reg <= 24'd65536;
            diag_noise_reg     <= 24'd0;
            add_noise_reg      <= 1'b1;
            num_features_reg   <= 7'd1;
            acc_reg            <= '0;
            cnt_reg            <= '0;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    sek_pkg::REG_HALF_INV_SQ:    half_inv_sq_reg    <= cfg_data;
                    sek_pkg::REG_VERTICAL_SCALE: vertical_scale_reg <= cfg_data;
                    sek_pkg::REG_DIAG_NOISE:     diag_noise_reg     <= cfg_data;
                    sek_pkg::REG_ADD_NOISE:      add_noise_reg      <= cfg_data[0];
                    sek_pkg::REG_NUM_FEATURES:   num_features_reg   <= cfg_data[6:0];
                    default:                     ;
                endcase
            end
            if (cmd.op == sek_pkg::OP_ACC)
            begin
                acc_reg <= complete ? '0 : sum_sat;
                cnt_reg <= complete ? '0 : cnt_inc9[CNT_W-1:0];
            end
            if (cmd.op == sek_pkg::OP_LOAD)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            sek_pkg::OP_ACC:
            begin
                if (complete)
                begin
                    dist_reg <= sum_sat;
                    diag_reg <= add_noise_reg && (s_tdata[51:32] == s_tdata[71:52]);
                end
            end
            sek_pkg::OP_MUL_LO:
                p_reg <= 64'(half_inv_sq_reg) * 64'(dist_reg[19:0]);
            sek_pkg::OP_MUL_HI:
                p_reg <= p_reg + ((64'(half_inv_sq_reg) * 64'(dist_reg[39:20])) << 20);
            sek_pkg::OP_RANGE:
            begin
                x_reg <= p_reg[44:8];
                n_reg <= '0;
                e_reg <= '0;
            end
            sek_pkg::OP_DIVN:
            begin
                if (ge_ln2)
                    x_reg <= 37'({1'b0, x_reg} - ln2_shift);
                n_reg[cmd.step[2:0]] <= ge_ln2;
                t_reg <= sek_pkg::ONE_Q32;
            end
            sek_pkg::OP_HMUL:
                q_reg <= rt_prod[63:32];
            sek_pkg::OP_HDIV:
                q_reg <= quot;
            sek_pkg::OP_HUPD:
                t_reg <= sek_pkg::ONE_Q32 - {1'b0, q_reg};
            sek_pkg::OP_SHIFT:
                e_reg <= (n_reg >= 6'd40) ? 33'd0 : (t_reg >> n_reg);
            sek_pkg::OP_SCALE:
                cov_reg <= cov_sum[32] ? {32{1'b1}} : cov_sum[31:0];
            sek_pkg::OP_LOAD:
                m_tdata_reg <= cov_reg;
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == sek_pkg::OP_LOAD |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten before it was taken");

    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == sek_pkg::OP_HMUL |-> x_reg < 37'(sek_pkg::LN2_Q32))
        else $error("range reduction left remainder above ln 2");

    a_term: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == sek_pkg::OP_HDIV |-> (cmd.term != 4'd0 && cmd.term <= sek_pkg::SERIES_TERMS))
        else $error("series divisor out of range");

endmodule

### rtl/sek_ctrl.sv
// ----------------------------------------------------------------------------
// sek_ctrl
// sequencer for accumulation, range reduction, series and output load
// ----------------------------------------------------------------------------
module sek_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  sek_pkg::status_t status,
    output sek_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_RANGE,
        ST_DIVN,
        ST_HMUL,
        ST_HDIV,
        ST_HUPD,
        ST_SHIFT,
        ST_SCALE,
        ST_OUT
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [4:0] step_reg;
    logic [4:0] step_next;
    logic [3:0] term_reg;
    logic [3:0] term_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        term_next  = term_reg;
        cmd.op     = sek_pkg::OP_NONE;
        cmd.step   = step_reg;
        cmd.term   = term_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op = sek_pkg::OP_ACC;
                    if (status.complete)
                        state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO:
            begin
                cmd.op     = sek_pkg::OP_MUL_LO;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.op     = sek_pkg::OP_MUL_HI;
                state_next = ST_RANGE;
            end
            ST_RANGE:
            begin
                cmd.op     = sek_pkg::OP_RANGE;
                step_next  = sek_pkg::RANGE_STEPS;
                state_next = status.cutoff ? ST_SCALE : ST_DIVN;
            end
            ST_DIVN:
            begin
                cmd.op = sek_pkg::OP_DIVN;
                if (step_reg == 5'd0)
                begin
                    term_next  = sek_pkg::SERIES_TERMS;
                    state_next = ST_HMUL;
                end
                else
                    step_next = step_reg - 5'd1;
            end
            ST_HMUL:
            begin
                cmd.op     = sek_pkg::OP_HMUL;
                state_next = ST_HDIV;
            end
            ST_HDIV:
            begin
                cmd.op     = sek_pkg::OP_HDIV;
                state_next = ST_HUPD;
            end
            ST_HUPD:
            begin
                cmd.op = sek_pkg::OP_HUPD;
                if (term_reg == 4'd1)
                    state_next = ST_SHIFT;
                else
                begin
                    term_next  = term_reg - 4'd1;
                    state_next = ST_HMUL;
                end
            end
            ST_SHIFT:
            begin
                cmd.op     = sek_pkg::OP_SHIFT;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.op     = sek_pkg::OP_SCALE;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = sek_pkg::OP_LOAD;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            term_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            term_reg  <= term_next;
        end
    end

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && status.complete |=> state_reg == ST_MUL_LO)
        else $error("completed pair did not start evaluation");

    a_divn_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIVN |-> step_reg <= sek_pkg::RANGE_STEPS)
        else $error("range reduction step out of range");

    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && status.out_free |=> state_reg == ST_IDLE)
        else $error("free output slot not used");

endmodule

### rtl/squared_exponential_kernel_unit.sv
// ----------------------------------------------------------------------------
// squared_exponential_kernel_unit
// squared-exponential covariance of one pair of points, fed one feature a word
//
// input channel s_*: one word per feature pair with both indices; every
// num_features words close a pair and give one covariance word on m_*.
// config channel cfg_*: always ready, index selects half_inv_sq, vertical_scale,
// diagonal noise, add_noise, num_features; write only while the unit is idle.
// a word that does not close a pair is taken and the next can follow at
// once. a closing word starts the exponential: a low and a high multiply,
// a range step, 6 ln 2 reduction steps and 10 series terms, each a multiply,
// a reciprocal multiply for the divide and an update, then shift, scale and
// load; past the cutoff the range step goes straight to scale and load.
// s_tready stays low meanwhile, so the next word is taken only once the
// result is loaded into the output register.
// the output register holds one result; while it waits for m_tready the unit
// keeps taking input words, and a finished result waits for the slot to free.
// reset restores register defaults and clears the accumulator and count.
// ----------------------------------------------------------------------------
module squared_exponential_kernel_unit #(
    parameter int MAX_FEATURES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // z_row[15:0], z_col[31:16], row_index[51:32], col_index[71:52]
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // covariance[31:0]
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    sek_pkg::cmd_t    cmd;
    sek_pkg::status_t status;

    assign cfg_ready = 1'b1;

    sek_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sek_datapath #(
        .MAX_FEATURES (MAX_FEATURES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### sim/squared_exponential_kernel_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// squared_exponential_kernel_unit_test
// self-checking bench: streams feature pairs through several register
// settings, predicts each covariance word in fixed point and compares it
// with what the unit delivers under random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module squared_exponential_kernel_unit_test;

    localparam int MAX_FEAT = 64;
    localparam logic [63:0] LN2_FIX = 64'd2977044472;
    localparam logic [63:0] ONE_FIX = 64'h1_0000_0000;
    localparam logic [63:0] CUTOFF_FIX = 64'd32 << 40;
    localparam logic [39:0] DIST_SAT = 40'hFF_FFFF_FFFF;

    class cov_scoreboard;
        logic [23:0] inv_sq;
        logic [23:0] v_scale;
        logic [23:0] noise;
        logic        noise_on;
        logic [6:0]  n_feat;
        logic [39:0] dist_acc;
        int          feat_seen;
        logic [31:0] cov_queue[$];
        int          errors;
        int          checked;

        function new();
            inv_sq = 24'd65536;
            v_scale = 24'd65536;
            noise = 24'd0;
            noise_on = 1'b1;
            n_feat = 7'd1;
            dist_acc = '0;
            feat_seen = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(sek_pkg::cfg_reg_t idx, logic [23:0] val);
            case (idx)
                sek_pkg::REG_HALF_INV_SQ:    inv_sq = val;
                sek_pkg::REG_VERTICAL_SCALE: v_scale = val;
                sek_pkg::REG_DIAG_NOISE:     noise = val;
                sek_pkg::REG_ADD_NOISE:      noise_on = val[0];
                sek_pkg::REG_NUM_FEATURES:   n_feat = val[6:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] exp_neg(logic [63:0] p);
            logic [63:0] x;
            logic [63:0] n;
            logic [63:0] r;
            logic [63:0] t;
            logic [127:0] prod;
            if (p >= CUTOFF_FIX)
                return 64'd0;
            x = p >> 8;
            n = x / LN2_FIX;
            r = x - n * LN2_FIX;
            t = ONE_FIX;
            for (int k = 10; k >= 1; k--)
            begin
                prod = r * t;
                t = ONE_FIX - (prod[95:32] / k);
            end
            if (n >= 40)
                return 64'd0;
            return t >> n;
        endfunction

        function void note_word(logic [71:0] w);
            logic signed [16:0] d;
            logic [33:0] sq;
            logic [40:0] sum;
            logic [63:0] e;
            logic [95:0] scaled;
            logic [32:0] cov;
            int need;
            d = $signed(w[15:0]) - $signed(w[31:16]);
            sq = d * d;
            sum = dist_acc + sq;
            dist_acc = (sum > DIST_SAT) ? DIST_SAT : sum[39:0];
            feat_seen++;
            need = n_feat;
            if (need < 1)
                need = 1;
            if (need > MAX_FEAT)
                need = MAX_FEAT;
            if (feat_seen < need)
                return;
            e = exp_neg(64'(inv_sq) * 64'(dist_acc));
            scaled = 96'(v_scale) * 96'(e) + (96'd1 << 31);
            cov = 33'(scaled >> 32);
            if (noise_on && w[51:32] == w[71:52])
                cov = cov + noise;
            if (cov > 33'hFFFF_FFFF)
                cov = 33'hFFFF_FFFF;
            cov_queue = {cov_queue, cov[31:0]};
            dist_acc = '0;
            feat_seen = 0;
        endfunction

        function void check_word(logic [31:0] got);
            logic [31:0] want;
            if (cov_queue.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected covariance word %h", got);
                return;
            end
            want = cov_queue.pop_front();
            checked++;
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("covariance mismatch: expected %h actual %h", want, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    cov_scoreboard board;
    int words_sent;
    int stall_mode;

    squared_exponential_kernel_unit #(.MAX_FEATURES(MAX_FEAT)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #200ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    // receiver stalls in phases: none, light, heavy, about half the time
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            board.check_word(m_tdata);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ($urandom_range(0, 40) > 20);
        endcase
    end

    task automatic write_reg(sek_pkg::cfg_reg_t idx, logic [23:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_reg(idx, val);
    endtask

    task automatic send_word(logic [15:0] zr, logic [15:0] zc, logic [19:0] ri,
                             logic [19:0] ci);
        s_tvalid <= 1'b1;
        s_tdata <= {ci, ri, zc, zr};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_word({ci, ri, zc, zr});
        words_sent++;
    endtask

    task automatic pause_word(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.cov_queue.size() != 0)
            @(posedge clk);
        repeat (400)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_z();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 8191)) - 16'd4096;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_pair(int feats, int gap_mode);
        logic [19:0] ri;
        logic [19:0] ci;
        logic [15:0] base;
        logic [15:0] zc;
        ri = 20'($urandom());
        ci = ($urandom_range(0, 1) != 0) ? ri : 20'($urandom());
        for (int f = 0; f < feats; f++)
        begin
            base = pick_z();
            if ($urandom_range(0, 2) == 0)
                zc = base + 16'($urandom_range(0, 255)) - 16'd128;
            else
                zc = pick_z();
            send_word(base, zc, ri, ci);
            if (gap_mode != 0 && $urandom_range(0, 7) == 0)
                pause_word($urandom_range(1, 6));
        end
    endtask

    task automatic run_phase(int words, int gap_mode);
        int feats;
        int sent;
        sent = 0;
        feats = board.n_feat;
        if (feats < 1)
            feats = 1;
        if (feats > MAX_FEAT)
            feats = MAX_FEAT;
        while (sent < words)
        begin
            send_pair(feats, gap_mode);
            sent += feats;
            if (gap_mode != 0 && $urandom_range(0, 3) == 0)
                pause_word($urandom_range(1, 20));
        end
        drain();
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = sek_pkg::REG_HALF_INV_SQ;
        cfg_data = '0;
        words_sent = 0;
        stall_mode = 0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset defaults, field extremes, diagonal and off-diagonal
        send_word(16'h7FFF, 16'h8000, 20'hFFFFF, 20'hFFFFF);
        send_word(16'h8000, 16'h7FFF, 20'h0, 20'hFFFFF);
        send_word(16'h0000, 16'h0000, 20'h12345, 20'h12345);
        send_word(16'h1000, 16'h0000, 20'h0, 20'h1);
        send_word(16'hFFFF, 16'h0001, 20'h5, 20'h5);
        drain();
        write_reg(sek_pkg::REG_DIAG_NOISE, 24'hFFFFFF);
        write_reg(sek_pkg::REG_VERTICAL_SCALE, 24'hFFFFFF);
        send_word(16'h0000, 16'h0000, 20'hAAAAA, 20'hAAAAA);
        send_word(16'h0100, 16'h0000, 20'h55555, 20'h55555);
        drain();
        write_reg(sek_pkg::REG_ADD_NOISE, 24'd0);
        write_reg(sek_pkg::REG_HALF_INV_SQ, 24'd0);
        send_word(16'h7FFF, 16'h8000, 20'h3, 20'h3);
        drain();
        write_reg(sek_pkg::REG_ADD_NOISE, 24'd1);
        write_reg(sek_pkg::REG_HALF_INV_SQ, 24'hFFFFFF);
        write_reg(sek_pkg::REG_VERTICAL_SCALE, 24'd0);
        send_word(16'h0001, 16'h0000, 20'h7, 20'h7);
        send_word(16'h0000, 16'h0000, 20'h7, 20'h8);
        drain();
        // count of zero acts as one, unknown index is ignored
        write_reg(sek_pkg::REG_NUM_FEATURES, 24'd0);
        write_reg(sek_pkg::cfg_reg_t'(3'd7), 24'hFFFFFF);
        write_reg(sek_pkg::REG_VERTICAL_SCALE, 24'd65536);
        write_reg(sek_pkg::REG_HALF_INV_SQ, 24'd1000);
        send_word(16'h0400, 16'h0000, 20'h9, 20'h9);
        drain();
        write_reg(sek_pkg::REG_NUM_FEATURES, 24'd127);
        run_phase(MAX_FEAT, 0);
        // change of count mid-pair: the next word closes it
        write_reg(sek_pkg::REG_NUM_FEATURES, 24'd4);
        send_word(16'h0200, 16'h0100, 20'h1, 20'h2);
        send_word(16'h0200, 16'h0100, 20'h1, 20'h2);
        send_word(16'h0200, 16'h0100, 20'h1, 20'h2);
        drain();
        write_reg(sek_pkg::REG_NUM_FEATURES, 24'd2);
        send_word(16'h0300, 16'h0100, 20'h4, 20'h4);
        drain();

        // random phases over a spread of settings
        for (int ph = 0; ph < 12; ph++)
        begin
            stall_mode = ph % 4;
            write_reg(sek_pkg::REG_HALF_INV_SQ,
                      (ph % 3 == 0) ? 24'($urandom_range(0, 4096)) : 24'($urandom()));
            write_reg(sek_pkg::REG_VERTICAL_SCALE, 24'($urandom()));
            write_reg(sek_pkg::REG_DIAG_NOISE, 24'($urandom()));
            write_reg(sek_pkg::REG_ADD_NOISE, 24'($urandom_range(0, 1)));
            write_reg(sek_pkg::REG_NUM_FEATURES,
                      (ph == 5) ? 24'd64 : 24'($urandom_range(1, 4)));
            run_phase(63, ph % 2 + (ph == 7 ? 0 : 1));
        end

        stall_mode = 0;
        drain();
        $display("sent %0d feature words, checked %0d covariance words", words_sent,
                 board.checked);
        $display("covered field extremes, diagonal noise, cutoff and register extremes");
        if (board.errors == 0 && board.cov_queue.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
